// ===== hdl/pcd_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// PID controller with deadband: shared package
// Field widths, fixed-point limits and configuration register indexes.
// ---------------------------------------------------------------------------
package pcd_pkg;

    localparam int VAL_W   = 24;   // measured and setpoint, Q15.8
    localparam int ERR_W   = 25;   // error, Q16.8
    localparam int DLT_W   = 26;   // error difference
    localparam int GAIN_W  = 32;   // gains, Q15.16
    localparam int DT_W    = 24;   // step time, Q8.16
    localparam int ACC_W   = 48;   // saturating values
    localparam int DRV_W   = 21;   // clamped drive
    localparam int IDX_W   = 3;    // configuration index
    localparam int FRAC    = 16;

    localparam int MUL_STEPS = 32;  // one multiplier bit per cycle
    localparam int DIV_STEPS = 58;  // one quotient bit per cycle
    localparam int DIV_W     = 58;  // |u| (42 bits) shifted left by FRAC
    localparam int CNT_W     = 6;

    localparam logic [ACC_W-1:0] SAT_POS = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] SAT_NEG = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] DRIVE_LIM     = 48'sd1048320;
    localparam logic signed [ERR_W-1:0] DEADBAND_HALF = 25'sd128;

    localparam logic [IDX_W-1:0] CFG_SETPOINT = 3'd0;
    localparam logic [IDX_W-1:0] CFG_GAIN_P   = 3'd1;
    localparam logic [IDX_W-1:0] CFG_GAIN_I   = 3'd2;
    localparam logic [IDX_W-1:0] CFG_GAIN_D   = 3'd3;

endpackage

// ===== hdl/pid_controller_deadband_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// PID controller with zero-setpoint deadband
// Bit-serial fixed-point PID step with saturating integral and output clamp.
// ---------------------------------------------------------------------------
// One request on the input channel yields exactly one result. A deadband
// request (setpoint zero and |error| below one half) goes from the accepting
// cycle straight to ST_PUB, which loads the output register. A full step runs
// the accepting cycle, then four signed products on a
// single shift-add multiplier that handles one multiplier bit per cycle, each
// product saturated in ST_MDONE, then a restoring divider that produces
// one quotient bit per cycle, then ST_DFIN to finish the quotient, ST_FIN to
// form the sum and clamp it, and ST_PUB to load the output register. The next
// request is taken while a finished result still waits at the output.
module pid_controller_deadband_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [pcd_pkg::VAL_W-1:0]     measured,
    input  logic [pcd_pkg::DT_W-1:0]      step_time,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pcd_pkg::DRV_W-1:0]     drive,
    output logic [pcd_pkg::ACC_W-1:0]     raw_drive,
    output logic [pcd_pkg::ERR_W-1:0]     error_value,
    output logic                          in_deadband,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pcd_pkg::IDX_W-1:0]     cfg_index,
    input  logic [pcd_pkg::GAIN_W-1:0]    cfg_data
);
    import pcd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_MDONE, ST_DIV, ST_DFIN, ST_FIN, ST_PUB
    } state_t;

    typedef enum logic [1:0] {OP_P, OP_T, OP_I, OP_U} op_t;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [VAL_W-1:0]  setpoint_reg, setpoint_next;
    logic [GAIN_W-1:0] gain_p_reg, gain_p_next;
    logic [GAIN_W-1:0] gain_i_reg, gain_i_next;
    logic [GAIN_W-1:0] gain_d_reg, gain_d_next;

    logic [ACC_W-1:0] error_sum_reg, error_sum_next;
    logic [ERR_W-1:0] last_error_reg, last_error_next;
    logic [ACC_W-1:0] last_raw_reg, last_raw_next;
    logic [ERR_W-1:0] last_seen_reg, last_seen_next;

    logic [ERR_W-1:0] err_reg, err_next;
    logic [DT_W-1:0]  dt_reg, dt_next;
    logic [DLT_W-1:0] delta_reg, delta_next;

    logic [ACC_W-1:0]  mc_reg, mc_next;
    logic [GAIN_W-1:0] mp_reg, mp_next;
    logic [ACC_W:0]    acc_hi_reg, acc_hi_next;
    logic [GAIN_W-1:0] acc_lo_reg, acc_lo_next;
    logic [ACC_W+1:0]  raw_acc_reg, raw_acc_next;

    logic              u_neg_reg, u_neg_next;
    logic              u_zero_reg, u_zero_next;
    logic [DIV_W-1:0]  dnum_reg, dnum_next;
    logic [DT_W-1:0]   rem_reg, rem_next;
    logic [ACC_W-1:0]  d_reg, d_next;

    logic [DRV_W-1:0] res_drive_reg, res_drive_next;
    logic             res_dead_reg, res_dead_next;

    logic             out_valid_reg, out_valid_next;
    logic [DRV_W-1:0] drive_reg, drive_next;
    logic [ACC_W-1:0] raw_drive_reg, raw_drive_next;
    logic [ERR_W-1:0] error_value_reg, error_value_next;
    logic             in_deadband_reg, in_deadband_next;

    // Combinational helpers
    logic [ERR_W-1:0]        err_in;
    logic                    dead_in;
    logic [ACC_W:0]          es_sum;
    logic [ACC_W-1:0]        es_sat;
    logic [ACC_W+1:0]        mul_add, mul_sum;
    logic [ACC_W+GAIN_W:0]   prod_full;
    logic [ACC_W+16:0]       prod_sh;
    logic [ACC_W-1:0]        prod_sat;
    logic [ACC_W-1:0]        u_mag;
    logic [DT_W:0]           rem_sh;
    logic                    rem_ge;
    logic [ACC_W+1:0]        fin_sum;
    logic [ACC_W-1:0]        fin_raw;

    assign in_ready    = (state_reg == ST_IDLE);
    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign drive       = drive_reg;
    assign raw_drive   = raw_drive_reg;
    assign error_value = error_value_reg;
    assign in_deadband = in_deadband_reg;

    always_comb
    begin
        err_in  = {setpoint_reg[VAL_W-1], setpoint_reg} - {measured[VAL_W-1], measured};
        dead_in = (setpoint_reg == '0) && ($signed(err_in) > -DEADBAND_HALF)
                  && ($signed(err_in) < DEADBAND_HALF);
        es_sum  = {error_sum_reg[ACC_W-1], error_sum_reg}
                  + {{(ACC_W-ERR_W+1){err_in[ERR_W-1]}}, err_in};
        if (es_sum[ACC_W] != es_sum[ACC_W-1])
        begin
            es_sat = es_sum[ACC_W] ? SAT_NEG : SAT_POS;
        end
        else
        begin
            es_sat = es_sum[ACC_W-1:0];
        end

        // The multiplier's sign bit carries negative weight.
        if (!mp_reg[0])
        begin
            mul_add = '0;
        end
        else if (cnt_reg == CNT_W'(MUL_STEPS - 1))
        begin
            mul_add = '0 - {{2{mc_reg[ACC_W-1]}}, mc_reg};
        end
        else
        begin
            mul_add = {{2{mc_reg[ACC_W-1]}}, mc_reg};
        end
        mul_sum = {acc_hi_reg[ACC_W], acc_hi_reg} + mul_add;

        prod_full = {acc_hi_reg, acc_lo_reg};
        prod_sh   = prod_full[ACC_W+GAIN_W:FRAC];
        if (prod_sh[ACC_W+16:ACC_W-1] != '0 && prod_sh[ACC_W+16:ACC_W-1] != '1)
        begin
            prod_sat = prod_sh[ACC_W+16] ? SAT_NEG : SAT_POS;
        end
        else
        begin
            prod_sat = prod_sh[ACC_W-1:0];
        end
        u_mag = prod_sat[ACC_W-1] ? ('0 - prod_sat) : prod_sat;

        rem_sh = {rem_reg, dnum_reg[DIV_W-1]};
        rem_ge = (rem_sh >= {1'b0, dt_reg});

        fin_sum = raw_acc_reg + {{2{d_reg[ACC_W-1]}}, d_reg};
        if (fin_sum[ACC_W+1:ACC_W-1] != '0 && fin_sum[ACC_W+1:ACC_W-1] != '1)
        begin
            fin_raw = fin_sum[ACC_W+1] ? SAT_NEG : SAT_POS;
        end
        else
        begin
            fin_raw = fin_sum[ACC_W-1:0];
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        cnt_next         = cnt_reg;
        setpoint_next    = setpoint_reg;
        gain_p_next      = gain_p_reg;
        gain_i_next      = gain_i_reg;
        gain_d_next      = gain_d_reg;
        error_sum_next   = error_sum_reg;
        last_error_next  = last_error_reg;
        last_raw_next    = last_raw_reg;
        last_seen_next   = last_seen_reg;
        err_next         = err_reg;
        dt_next          = dt_reg;
        delta_next       = delta_reg;
        mc_next          = mc_reg;
        mp_next          = mp_reg;
        acc_hi_next      = acc_hi_reg;
        acc_lo_next      = acc_lo_reg;
        raw_acc_next     = raw_acc_reg;
        u_neg_next       = u_neg_reg;
        u_zero_next      = u_zero_reg;
        dnum_next        = dnum_reg;
        rem_next         = rem_reg;
        d_next           = d_reg;
        res_drive_next   = res_drive_reg;
        res_dead_next    = res_dead_reg;
        out_valid_next   = out_valid_reg;
        drive_next       = drive_reg;
        raw_drive_next   = raw_drive_reg;
        error_value_next = error_value_reg;
        in_deadband_next = in_deadband_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SETPOINT: setpoint_next = cfg_data[VAL_W-1:0];
                CFG_GAIN_P:   gain_p_next   = cfg_data;
                CFG_GAIN_I:   gain_i_next   = cfg_data;
                CFG_GAIN_D:   gain_d_next   = cfg_data;
                default:      ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (dead_in)
                    begin
                        res_drive_next = '0;
                        res_dead_next  = 1'b1;
                        state_next     = ST_PUB;
                    end
                    else
                    begin
                        error_sum_next = es_sat;
                        err_next       = err_in;
                        dt_next        = step_time;
                        delta_next     = {err_in[ERR_W-1], err_in}
                                         - {last_error_reg[ERR_W-1], last_error_reg};
                        mc_next        = {{(ACC_W-ERR_W){err_in[ERR_W-1]}}, err_in};
                        mp_next        = gain_p_reg;
                        acc_hi_next    = '0;
                        acc_lo_next    = '0;
                        cnt_next       = '0;
                        op_next        = OP_P;
                        res_dead_next  = 1'b0;
                        state_next     = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                acc_hi_next = mul_sum[ACC_W+1:1];
                acc_lo_next = {mul_sum[0], acc_lo_reg[GAIN_W-1:1]};
                mp_next     = {1'b0, mp_reg[GAIN_W-1:1]};
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MUL_STEPS - 1))
                begin
                    state_next = ST_MDONE;
                end
            end
            ST_MDONE:
            begin
                acc_hi_next = '0;
                acc_lo_next = '0;
                cnt_next    = '0;
                state_next  = ST_MUL;
                unique case (op_reg)
                    OP_P:
                    begin
                        raw_acc_next = {{2{prod_sat[ACC_W-1]}}, prod_sat};
                        mc_next      = error_sum_reg;
                        mp_next      = gain_i_reg;
                        op_next      = OP_T;
                    end
                    OP_T:
                    begin
                        mc_next = prod_sat;
                        mp_next = {{(GAIN_W-DT_W){1'b0}}, dt_reg};
                        op_next = OP_I;
                    end
                    OP_I:
                    begin
                        raw_acc_next = raw_acc_reg + {{2{prod_sat[ACC_W-1]}}, prod_sat};
                        mc_next      = {{(ACC_W-DLT_W){delta_reg[DLT_W-1]}}, delta_reg};
                        mp_next      = gain_d_reg;
                        op_next      = OP_U;
                    end
                    OP_U:
                    begin
                        u_neg_next  = prod_sat[ACC_W-1];
                        u_zero_next = (prod_sat == '0);
                        dnum_next   = {u_mag[DIV_W-FRAC-1:0], {FRAC{1'b0}}};
                        rem_next    = '0;
                        state_next  = ST_DIV;
                    end
                    default: ;
                endcase
            end
            ST_DIV:
            begin
                rem_next  = rem_ge ? DT_W'(rem_sh - {1'b0, dt_reg}) : rem_sh[DT_W-1:0];
                dnum_next = {dnum_reg[DIV_W-2:0], rem_ge};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_DFIN;
                end
            end
            ST_DFIN:
            begin
                // Negative quotients round toward minus infinity.
                priority if (u_zero_reg)
                begin
                    d_next = '0;
                end
                else if (dnum_reg[DIV_W-1:ACC_W-1] != '0)
                begin
                    d_next = u_neg_reg ? SAT_NEG : SAT_POS;
                end
                else if (u_neg_reg)
                begin
                    d_next = '0 - {1'b0, dnum_reg[ACC_W-2:0]}
                             - {{(ACC_W-1){1'b0}}, (rem_reg != '0)};
                end
                else
                begin
                    d_next = {1'b0, dnum_reg[ACC_W-2:0]};
                end
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                last_raw_next   = fin_raw;
                last_seen_next  = err_reg;
                last_error_next = err_reg;
                priority if ($signed(fin_raw) > DRIVE_LIM)
                begin
                    res_drive_next = DRIVE_LIM[DRV_W-1:0];
                end
                else if ($signed(fin_raw) < -DRIVE_LIM)
                begin
                    res_drive_next = DRV_W'(-DRIVE_LIM);
                end
                else
                begin
                    res_drive_next = fin_raw[DRV_W-1:0];
                end
                state_next = ST_PUB;
            end
            ST_PUB:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    drive_next       = res_drive_reg;
                    raw_drive_next   = last_raw_reg;
                    error_value_next = last_seen_reg;
                    in_deadband_next = res_dead_reg;
                    state_next       = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            op_reg         <= OP_P;
            cnt_reg        <= '0;
            setpoint_reg   <= '0;
            gain_p_reg     <= '0;
            gain_i_reg     <= '0;
            gain_d_reg     <= '0;
            error_sum_reg  <= '0;
            last_error_reg <= '0;
            last_raw_reg   <= '0;
            last_seen_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            cnt_reg        <= cnt_next;
            setpoint_reg   <= setpoint_next;
            gain_p_reg     <= gain_p_next;
            gain_i_reg     <= gain_i_next;
            gain_d_reg     <= gain_d_next;
            error_sum_reg  <= error_sum_next;
            last_error_reg <= last_error_next;
            last_raw_reg   <= last_raw_next;
            last_seen_reg  <= last_seen_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg         <= err_next;
        dt_reg          <= dt_next;
        delta_reg       <= delta_next;
        mc_reg          <= mc_next;
        mp_reg          <= mp_next;
        acc_hi_reg      <= acc_hi_next;
        acc_lo_reg      <= acc_lo_next;
        raw_acc_reg     <= raw_acc_next;
        u_neg_reg       <= u_neg_next;
        u_zero_reg      <= u_zero_next;
        dnum_reg        <= dnum_next;
        rem_reg         <= rem_next;
        d_reg           <= d_next;
        res_drive_reg   <= res_drive_next;
        res_dead_reg    <= res_dead_next;
        drive_reg       <= drive_next;
        raw_drive_reg   <= raw_drive_next;
        error_value_reg <= error_value_next;
        in_deadband_reg <= in_deadband_next;
    end

    a_pub_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUB && out_valid_reg && !out_ready) |=> (state_reg == ST_PUB))
        else $error("finished result overwrote a pending output");

    a_drive_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ($signed(drive_reg) <= 21'sd1048320
                           && $signed(drive_reg) >= -21'sd1048320))
        else $error("drive outside clamp limits");

    a_dead_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && in_deadband_reg) |-> (drive_reg == '0))
        else $error("deadband result with nonzero drive");

    a_mul_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |-> (cnt_reg < CNT_W'(MUL_STEPS)))
        else $error("multiplier step count overran");

endmodule

// ===== verif/pcd_result_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// PID deadband unit result checker
// Watches the configuration, request and result channels. It keeps its own
// copy of the controller state, predicts each result and compares it field
// by field.
// ---------------------------------------------------------------------------
module pcd_result_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [pcd_pkg::VAL_W-1:0]     measured,
    input  logic [pcd_pkg::DT_W-1:0]      step_time,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [pcd_pkg::DRV_W-1:0]     drive,
    input  logic [pcd_pkg::ACC_W-1:0]     raw_drive,
    input  logic [pcd_pkg::ERR_W-1:0]     error_value,
    input  logic                          in_deadband,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [pcd_pkg::IDX_W-1:0]     cfg_index,
    input  logic [pcd_pkg::GAIN_W-1:0]    cfg_data,
    output int                            fail_count,
    output int                            pending
);
    import pcd_pkg::*;

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic [DRV_W-1:0] drive;
        logic [ACC_W-1:0] raw_drive;
        logic [ERR_W-1:0] error_value;
        logic             in_deadband;
    } pid_result_t;

    pid_result_t pid_expected_q[$];

    // Shadow of the configuration registers and the controller state.
    logic signed [VAL_W-1:0]  sp;
    logic signed [GAIN_W-1:0] kp, ki, kd;
    wide_t integral, prev_error, held_raw, held_error;

    localparam wide_t POS48 = (wide_t'(1) <<< 47) - 1;
    localparam wide_t NEG48 = -(wide_t'(1) <<< 47);
    localparam wide_t DRV_MAX = 1048320;

    function automatic wide_t clip48(input wide_t x);
        if (x > POS48) return POS48;
        if (x < NEG48) return NEG48;
        return x;
    endfunction

    // Product scaled down by 2^16, rounded toward minus infinity.
    function automatic wide_t scaled_mul(input wide_t a, input wide_t b);
        wide_t prod;
        prod = a * b;
        return clip48(prod >>> FRAC);
    endfunction

    function automatic wide_t scaled_div(input wide_t u, input wide_t dt);
        wide_t num, q;
        if (u == 0) return 0;
        if (dt == 0) return (u < 0) ? NEG48 : POS48;
        num = u <<< FRAC;
        q = num / dt;
        if (num < 0 && (num % dt) != 0) q = q - 1;
        return clip48(q);
    endfunction

    function automatic pid_result_t predict_pid_step(input logic [VAL_W-1:0] meas_bits,
                                                     input logic [DT_W-1:0] dt_bits);
        wide_t meas, dt, err, p_term, i_term, d_term, raw, drv;
        logic dead;
        pid_result_t r;
        meas = wide_t'($signed(meas_bits));
        dt   = wide_t'({1'b0, dt_bits});
        err  = wide_t'(sp) - meas;
        dead = (sp == 0) && (err > -128) && (err < 128);
        drv  = 0;
        if (!dead)
        begin
            integral = clip48(integral + err);
            p_term = scaled_mul(wide_t'(kp), err);
            i_term = scaled_mul(scaled_mul(wide_t'(ki), integral), dt);
            d_term = scaled_div(scaled_mul(wide_t'(kd), err - prev_error), dt);
            raw = clip48(p_term + i_term + d_term);
            held_raw   = raw;
            held_error = err;
            prev_error = err;
            drv = (raw > DRV_MAX) ? DRV_MAX : ((raw < -DRV_MAX) ? -DRV_MAX : raw);
        end
        r.drive       = drv[DRV_W-1:0];
        r.raw_drive   = held_raw[ACC_W-1:0];
        r.error_value = held_error[ERR_W-1:0];
        r.in_deadband = dead;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $time, field, got, want);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
    end

    assign pending = pid_expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        pid_result_t want;
        if (!rst_n)
        begin
            sp = '0;
            kp = '0;
            ki = '0;
            kd = '0;
            integral   = 0;
            prev_error = 0;
            held_raw   = 0;
            held_error = 0;
            pid_expected_q.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pid_expected_q.size() == 0)
                    report_mismatch("unexpected result", {43'd0, drive}, 64'd0);
                else
                begin
                    want = pid_expected_q.pop_front();
                    if (drive !== want.drive)
                        report_mismatch("drive", {43'd0, drive}, {43'd0, want.drive});
                    if (raw_drive !== want.raw_drive)
                        report_mismatch("raw_drive", {16'd0, raw_drive},
                                        {16'd0, want.raw_drive});
                    if (error_value !== want.error_value)
                        report_mismatch("error_value", {39'd0, error_value},
                                        {39'd0, want.error_value});
                    if (in_deadband !== want.in_deadband)
                        report_mismatch("in_deadband", {63'd0, in_deadband},
                                        {63'd0, want.in_deadband});
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SETPOINT: sp = cfg_data[VAL_W-1:0];
                    CFG_GAIN_P:   kp = cfg_data;
                    CFG_GAIN_I:   ki = cfg_data;
                    CFG_GAIN_D:   kd = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                pid_expected_q.push_back(predict_pid_step(measured, step_time));
        end
    end

endmodule

// ===== verif/tb_pid_controller_deadband_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// PID deadband unit testbench
// Drives directed and random requests over several gain settings and idle
// patterns; a checker beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
module tb_pid_controller_deadband_unit;
    import pcd_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int SETTLE      = 260;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [VAL_W-1:0]     measured;
    logic [DT_W-1:0]      step_time;
    logic                 out_valid;
    logic                 out_ready;
    logic [DRV_W-1:0]     drive;
    logic [ACC_W-1:0]     raw_drive;
    logic [ERR_W-1:0]     error_value;
    logic                 in_deadband;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [IDX_W-1:0]     cfg_index;
    logic [GAIN_W-1:0]    cfg_data;
    int                   fail_count;
    int                   pending;
    int                   cycle_count;
    int                   send_idle_pct;
    int                   recv_stall_pct;

    pid_controller_deadband_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .measured(measured), .step_time(step_time),
        .out_valid(out_valid), .out_ready(out_ready),
        .drive(drive), .raw_drive(raw_drive),
        .error_value(error_value), .in_deadband(in_deadband),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    pcd_result_checker checker_inst (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .measured(measured), .step_time(step_time),
        .out_valid(out_valid), .out_ready(out_ready),
        .drive(drive), .raw_drive(raw_drive),
        .error_value(error_value), .in_deadband(in_deadband),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Called at a rising edge; returns at the edge where the request is taken.
    task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        while (!cfg_ready) @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_request(input logic [VAL_W-1:0] meas, input logic [DT_W-1:0] dt);
        in_valid  <= 1'b1;
        measured  <= meas;
        step_time <= dt;
        @(negedge clk);
        while (!in_ready) @(negedge clk);
        @(posedge clk);
        // Gap after the request; valid stays high when none is drawn.
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        @(posedge clk);
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return 32'h0001_0000;
            4: return $urandom_range(32'h0004_0000);
            5: return -$urandom_range(32'h0004_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] pick_measured(input logic [VAL_W-1:0] target);
        case ($urandom_range(9))
            0: return 24'h7F_FFFF;
            1: return 24'h80_0000;
            2, 3: return target + 24'($signed($urandom_range(300)) - 150);
            4: return target + 24'($signed($urandom_range(40000)) - 20000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DT_W-1:0] pick_step_time();
        case ($urandom_range(9))
            0: return 24'h00_0001;
            1: return 24'hFF_FFFF;
            2, 3: return $urandom_range(24'h02_0000, 24'h00_0100);
            default: return $urandom_range(24'hFF_FFFF, 1);
        endcase
    endfunction

    initial
    begin
        logic [VAL_W-1:0] target;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        measured    = '0;
        step_time   = '0;
        out_ready   = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        cycle_count = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: deadband edges around a zero setpoint, then field extremes.
        cfg_write(CFG_GAIN_P, 32'h0001_0000);
        cfg_write(CFG_GAIN_I, 32'h0000_8000);
        cfg_write(CFG_GAIN_D, 32'h0000_4000);
        send_request(24'h00_0000, 24'h01_0000);
        send_request(24'h00_007F, 24'h01_0000);
        send_request(24'hFF_FF81, 24'h01_0000);
        send_request(24'h00_0080, 24'h01_0000);
        send_request(24'hFF_FF80, 24'h01_0000);
        send_request(24'h00_0010, 24'h00_0001);
        send_request(24'h7F_FFFF, 24'hFF_FFFF);
        send_request(24'h80_0000, 24'h00_0001);
        send_request(24'h00_1000, 24'h00_0000);
        send_request(24'h00_0001, 24'h00_0000);
        drain_results();
        cfg_write(CFG_SETPOINT, 32'h0000_0000 | 24'h7F_FFFF);
        cfg_write(CFG_GAIN_P, 32'h7FFF_FFFF);
        cfg_write(CFG_GAIN_I, 32'h8000_0000);
        cfg_write(CFG_GAIN_D, 32'h7FFF_FFFF);
        send_request(24'h80_0000, 24'hFF_FFFF);
        send_request(24'h7F_FFFF, 24'h00_0001);
        send_request(24'h80_0000, 24'h00_0001);
        drain_results();
        cfg_write(CFG_SETPOINT, 32'hFF80_0000);
        cfg_write(CFG_GAIN_P, 32'h8000_0000);
        cfg_write(3'd5, 32'hFFFF_FFFF);
        cfg_write(3'd7, 32'h1234_5678);
        send_request(24'h7F_FFFF, 24'hFF_FFFF);
        send_request(24'h00_0000, 24'h00_8000);
        send_request(24'h7F_FFFF, 24'h00_0001);
        drain_results();

        // Random phases, each with its own settings and one of four idle patterns.
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            drain_results();
            target = (phase % 2 == 0) ? 24'h0 : $urandom;
            cfg_write(CFG_SETPOINT, {$urandom} & 32'hFF00_0000 | target);
            cfg_write(CFG_GAIN_P, pick_gain());
            cfg_write(CFG_GAIN_I, pick_gain());
            cfg_write(CFG_GAIN_D, pick_gain());
            if ($urandom_range(1))
                cfg_write(IDX_W'($urandom_range(7, 4)), $urandom);
            for (int n = 0; n < 218; n++)
            begin
                send_request(pick_measured(target), pick_step_time());
                if (n == 100)
                    drain_results();
            end
        end

        drain_results();
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/pcd_pkg.sv
hdl/pid_controller_deadband_unit.sv
verif/pcd_result_checker.sv
verif/tb_pid_controller_deadband_unit.sv
